// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top level of the timer block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/mst_pkg.sv =====
// Package with types and constants of the multi-slot timer table.
`default_nettype none
package mst_pkg;

    // Number of timer slots in the table.
    localparam int SLOT_COUNT = 8;
    // Bits needed to address one slot.
    localparam int SLOT_IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    // Slot code returned when the table is full.
    localparam logic [3:0] SLOT_FULL = 4'(SLOT_COUNT);

    // Command codes of an input item; the fourth code is ignored.
    typedef enum logic [1:0] {
        ACT_TICK     = 2'd0,
        ACT_REGISTER = 2'd1,
        ACT_DELETE   = 2'd2
    } action_t;

    // Kinds of result item.
    typedef enum logic {
        EVT_REPLY = 1'b0,
        EVT_FIRE  = 1'b1
    } event_kind_t;

    // One input item.
    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  slot_index;
        logic [15:0] start_ticks;
        logic [15:0] reload_period;
        logic [15:0] tag;
    } in_item_t;

    // One result item.
    typedef struct packed {
        logic        event_kind;
        logic [3:0]  slot;
        logic [15:0] fired_tag;
        logic        last;
    } out_item_t;

    // Controller states.
    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_WALK = 1'b1
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_tick;
        logic step;
        logic do_register;
        logic do_delete;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic walk_last;
    } dp_status_t;

endpackage
`default_nettype wire

// ===== rtl/multi_slot_software_timer.sv =====
// Top level of the multi-slot timer table: controller, datapath and checks.
//
// Usage: drive an item on command and raise start; it is taken at a rising
// edge where start is high and busy is low. A register item claims the
// lowest free slot and returns one reply on result, with result_valid high
// for exactly one cycle, right after the accepting edge; the slot equals
// the slot count when the table is full. A delete item frees a slot, gives
// no result and leaves busy low. A tick walks the slots one per cycle, so
// busy stays high until the walk has passed the last slot, and no new
// item is taken before then; each firing slot shows one result,
// in ascending slot order, and the last one of the tick has last set.
// Register and delete items never raise busy; the rate is set by the
// serial slot walk. There is no output stall: each result stands for one
// cycle only and must be taken then. Reset frees and disarms every slot.
`default_nettype none
`include "assert_macros.svh"
module multi_slot_software_timer (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire mst_pkg::in_item_t command,
    output mst_pkg::out_item_t     result,
    output logic                   result_valid
);
    import mst_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // Sequencer.
    mst_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .action (command.action),
        .status (status),
        .busy   (busy),
        .cmd    (cmd)
    );

    // Slot table and result register.
    mst_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .command      (command),
        .status       (status),
        .result       (result),
        .result_valid (result_valid)
    );

    // A fire result only comes out of a cycle of the tick walk.
    `ASSERT_IMPL(a_fire_in_walk, clk, rst_n, result_valid && (result.event_kind == EVT_FIRE), $past(busy), "fire result outside a tick walk")
    // A register reply is always the single and final result of its item.
    `ASSERT_IMPL(a_reply_last, clk, rst_n, result_valid && (result.event_kind == EVT_REPLY), result.last && (result.fired_tag == 16'd0), "register reply malformed")
    // An accepted tick makes the block busy in the next cycle.
    `ASSERT_NEXT(a_tick_busy, clk, rst_n, start && !busy && (command.action == ACT_TICK), busy, "tick did not start a walk")
    // Only one command reaches the datapath in a cycle.
    `ASSERT_IMPL(a_cmd_onehot, clk, rst_n, 1'b1, $onehot0({cmd.load_tick, cmd.step, cmd.do_register, cmd.do_delete}), "conflicting datapath commands")

endmodule
`default_nettype wire

// ===== rtl/mst_ctrl.sv =====
// Controller state machine that sequences table updates and the tick walk.
`default_nettype none
module mst_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [1:0]         action,
    input  wire mst_pkg::dp_status_t status,
    output logic                    busy,
    output mst_pkg::ctrl_cmd_t      cmd
);
    import mst_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        accept;

    assign accept = start && (state_reg == ST_IDLE);

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state: a tick walks every slot once, other items finish at once.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (action == ACT_TICK))
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (status.walk_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs to the datapath and the command port.
    always_comb
    begin
        busy            = (state_reg == ST_WALK);
        cmd.load_tick   = accept && (action == ACT_TICK);
        cmd.do_register = accept && (action == ACT_REGISTER);
        cmd.do_delete   = accept && (action == ACT_DELETE);
        cmd.step        = (state_reg == ST_WALK);
    end

endmodule
`default_nettype wire

// ===== rtl/mst_dp.sv =====
// Datapath holding the slot table, the walk pointer and the result register.
`default_nettype none
module mst_dp (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire mst_pkg::ctrl_cmd_t cmd,
    input  wire mst_pkg::in_item_t  command,
    output mst_pkg::dp_status_t     status,
    output mst_pkg::out_item_t      result,
    output logic                    result_valid
);
    import mst_pkg::*;

    logic [SLOT_COUNT-1:0] in_use_reg;
    logic [SLOT_COUNT-1:0] in_use_next;
    logic [SLOT_COUNT-1:0] armed_reg;
    logic [SLOT_COUNT-1:0] armed_next;
    logic [15:0]           count_reg  [SLOT_COUNT];
    logic [15:0]           count_next [SLOT_COUNT];
    logic [15:0]           reload_reg  [SLOT_COUNT];
    logic [15:0]           reload_next [SLOT_COUNT];
    logic [15:0]           tag_reg  [SLOT_COUNT];
    logic [15:0]           tag_next [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] mask_reg;
    logic [SLOT_COUNT-1:0] mask_next;
    logic [SLOT_IDX_W-1:0] ptr_reg;
    logic [SLOT_IDX_W-1:0] ptr_next;
    out_item_t             result_reg;
    out_item_t             result_next;
    logic                  valid_reg;
    logic                  valid_next;

    logic [SLOT_COUNT-1:0] due_vec;
    logic [SLOT_COUNT-1:0] later_vec;
    logic                  free_found;
    logic [SLOT_IDX_W-1:0] free_idx;
    logic [SLOT_IDX_W-1:0] del_idx;
    logic                  del_in_range;
    logic [31:0]           ptr_wide;
    logic [31:0]           free_wide;

    // Slots that fire on this tick: claimed, armed and at most one tick left.
    always_comb
    begin
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            due_vec[i] = in_use_reg[i] && armed_reg[i] && (count_reg[i] <= 16'd1);
        end
    end

    // Slots after the pointer that still fire; none left marks the final result.
    always_comb
    begin
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            later_vec[i] = mask_reg[i] && (SLOT_IDX_W'(i) > ptr_reg);
        end
    end

    // Lowest free slot.
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--)
        begin
            if (!in_use_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = SLOT_IDX_W'(i);
            end
        end
    end

    assign del_in_range = (command.slot_index < 8'(SLOT_COUNT));
    assign del_idx      = command.slot_index[SLOT_IDX_W-1:0];
    assign ptr_wide     = 32'(ptr_reg);
    assign free_wide    = 32'(free_idx);

    assign status.walk_last = (ptr_reg == SLOT_IDX_W'(SLOT_COUNT - 1));

    // Table update, walk step and result formation.
    always_comb
    begin
        in_use_next = in_use_reg;
        armed_next  = armed_reg;
        count_next  = count_reg;
        reload_next = reload_reg;
        tag_next    = tag_reg;
        mask_next   = mask_reg;
        ptr_next    = ptr_reg;
        result_next = result_reg;
        valid_next  = 1'b0;

        priority if (cmd.load_tick)
        begin
            mask_next = due_vec;
            ptr_next  = '0;
        end
        else if (cmd.do_register)
        begin
            if (free_found)
            begin
                in_use_next[free_idx] = 1'b1;
                armed_next[free_idx]  = 1'b1;
                count_next[free_idx]  = command.start_ticks;
                reload_next[free_idx] = command.reload_period;
                tag_next[free_idx]    = command.tag;
            end
            result_next.event_kind = EVT_REPLY;
            result_next.slot       = free_found ? free_wide[3:0] : SLOT_FULL;
            result_next.fired_tag  = '0;
            result_next.last       = 1'b1;
            valid_next             = 1'b1;
        end
        else if (cmd.do_delete)
        begin
            if (del_in_range)
            begin
                in_use_next[del_idx] = 1'b0;
                armed_next[del_idx]  = 1'b0;
                count_next[del_idx]  = '0;
                reload_next[del_idx] = '0;
                tag_next[del_idx]    = '0;
            end
        end
        else if (cmd.step)
        begin
            // One slot per cycle: fire and reload or disarm, else count down.
            if (mask_reg[ptr_reg])
            begin
                count_next[ptr_reg] = reload_reg[ptr_reg];
                if (reload_reg[ptr_reg] == 16'd0)
                begin
                    armed_next[ptr_reg] = 1'b0;
                end
                result_next.event_kind = EVT_FIRE;
                result_next.slot       = ptr_wide[3:0];
                result_next.fired_tag  = tag_reg[ptr_reg];
                result_next.last       = ~|later_vec;
                valid_next             = 1'b1;
            end
            else if (in_use_reg[ptr_reg] && armed_reg[ptr_reg])
            begin
                count_next[ptr_reg] = count_reg[ptr_reg] - 16'd1;
            end
            ptr_next = ptr_reg + SLOT_IDX_W'(1);
        end
        else
        begin
            valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_use_reg <= '0;
            armed_reg  <= '0;
            valid_reg  <= 1'b0;
            ptr_reg    <= '0;
            mask_reg   <= '0;
        end
        else
        begin
            in_use_reg <= in_use_next;
            armed_reg  <= armed_next;
            valid_reg  <= valid_next;
            ptr_reg    <= ptr_next;
            mask_reg   <= mask_next;
        end
    end

    // Slot payload and result registers.
    always_ff @(posedge clk)
    begin
        count_reg  <= count_next;
        reload_reg <= reload_next;
        tag_reg    <= tag_next;
        result_reg <= result_next;
    end

    assign result       = result_reg;
    assign result_valid = valid_reg;

endmodule
`default_nettype wire
